[rtl/core/csw_pkg.sv]
// Shared types and constants for the clock and stopwatch block.
`default_nettype none

package csw_pkg;

  localparam int unsigned TICKS_PER_SECOND_DEF = 100;

  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [5:0] SIXTY_LAST = 6'd59;

  typedef enum logic [3:0] {
    FN_NONE       = 4'd0,
    FN_MODE       = 4'd1,
    FN_HOUR_UP    = 4'd2,
    FN_MIN_UP     = 4'd3,
    FN_ZERO_SECS  = 4'd4,
    FN_RESET      = 4'd5,
    FN_START_STOP = 4'd6,
    FN_PAUSE      = 4'd7,
    FN_LOAD       = 4'd8
  } func_t;

  // hours, minutes, seconds; the sub-second count is sized by the tick rate
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

  typedef struct packed {
    logic       showing_stopwatch;
    logic [4:0] disp_hours;
    logic [5:0] disp_minutes;
    logic [5:0] disp_seconds;
    logic [6:0] disp_centis;
    logic       running;
    logic       frozen;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/csw_if.sv]
// Valid/ready channel interfaces for tick words in and display words out.
`default_nettype none

interface csw_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] func;
  logic [4:0] load_hours;
  logic [5:0] load_minutes;
  logic [5:0] load_seconds;

  modport source (output valid, output func, output load_hours,
                  output load_minutes, output load_seconds, input ready);
  modport sink   (input valid, input func, input load_hours,
                  input load_minutes, input load_seconds, output ready);
endinterface

interface csw_out_if;
  logic       valid;
  logic       ready;
  logic       showing_stopwatch;
  logic [4:0] disp_hours;
  logic [5:0] disp_minutes;
  logic [5:0] disp_seconds;
  logic [6:0] disp_centis;
  logic       running;
  logic       frozen;

  modport source (output valid, output showing_stopwatch, output disp_hours,
                  output disp_minutes, output disp_seconds, output disp_centis,
                  output running, output frozen, input ready);
  modport sink   (input valid, input showing_stopwatch, input disp_hours,
                  input disp_minutes, input disp_seconds, input disp_centis,
                  input running, input frozen, output ready);
endinterface

`default_nettype wire

[rtl/core/csw_tick.sv]
// One tick of a centisecond/second/minute/hour cascade.
`default_nettype none

module csw_tick #(
  parameter int unsigned TICKS_PER_SECOND = csw_pkg::TICKS_PER_SECOND_DEF,
  localparam int unsigned CW = $clog2(TICKS_PER_SECOND)
) (
  input  wire logic          en,
  input  wire csw_pkg::hms_t t_in,
  input  wire logic [CW-1:0] c_in,
  output csw_pkg::hms_t      t_out,
  output logic      [CW-1:0] c_out
);

  localparam logic [CW-1:0] C_LAST = CW'(TICKS_PER_SECOND - 1);

  logic c_wrap, s_wrap, m_wrap, h_wrap;

  always_comb begin
    c_wrap = (c_in == C_LAST);
    s_wrap = (t_in.seconds == csw_pkg::SIXTY_LAST);
    m_wrap = (t_in.minutes == csw_pkg::SIXTY_LAST);
    h_wrap = (t_in.hours == csw_pkg::HOUR_LAST);
    t_out  = t_in;
    c_out  = c_in;
    if (en) begin
      c_out = c_wrap ? '0 : c_in + CW'(1);
      if (c_wrap) begin
        t_out.seconds = s_wrap ? '0 : t_in.seconds + 6'd1;
        if (s_wrap) begin
          t_out.minutes = m_wrap ? '0 : t_in.minutes + 6'd1;
          if (m_wrap) begin
            t_out.hours = h_wrap ? '0 : t_in.hours + 5'd1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/clock_and_stopwatch_top.sv]
// Digital clock with stopwatch: top level, state registers and output buffer.
//
// Each input word is one tick (1/TICKS_PER_SECOND s) with an optional command
// in func; load_* carry a clock time for the load command. The command acts
// first, then the stopwatch ticks if running and the clock always ticks; the
// lap shown in stopwatch view follows the stopwatch unless paused.
// Every input word yields exactly one output word with the view flag, the
// displayed time of the current view and the running/paused flags.
// A taken word is registered in the head, or in the skid while the head waits.
// Throughput: one word per cycle while in_ch.ready is high; each update is one
// pass through the command logic and two tick cascades between the state and
// output registers. Output side has a head register plus one skid register, so
// an input word is still taken while a finished word waits; in_ch.ready falls
// only when both hold words, i.e. after the receiver has stalled for two words.
// Reset (rst_n low, synchronous) clears the clock to 00:00:00.00, the
// stopwatch and lap to zero, selects clock view, stops and unpauses the
// stopwatch and empties the output buffer.
`default_nettype none

module clock_and_stopwatch_top #(
  parameter int unsigned TICKS_PER_SECOND = csw_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  csw_in_if.sink     in_ch,
  csw_out_if.source  out_ch
);

  localparam int unsigned CW = $clog2(TICKS_PER_SECOND);

  // state
  csw_pkg::hms_t clk_t_r, watch_t_r, lap_t_r;
  logic [CW-1:0] clk_c_r, watch_c_r, lap_c_r;
  logic          view_r, run_r, pause_r;

  // after command
  csw_pkg::hms_t cmd_clk_t, cmd_watch_t, cmd_lap_t;
  logic [CW-1:0] cmd_clk_c, cmd_watch_c, cmd_lap_c;
  logic          view_nxt, run_nxt, pause_nxt;

  // after tick
  csw_pkg::hms_t clk_t_nxt, watch_t_nxt, lap_t_nxt;
  logic [CW-1:0] clk_c_nxt, watch_c_nxt, lap_c_nxt;

  csw_pkg::func_t   func;
  csw_pkg::result_t res;
  csw_pkg::result_t head_r, skid_r;
  logic             head_vld_r, skid_vld_r;
  logic             accept, pop;

  assign func   = csw_pkg::func_t'(in_ch.func);
  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = head_vld_r && out_ch.ready;

  always_comb begin
    cmd_clk_t   = clk_t_r;
    cmd_clk_c   = clk_c_r;
    cmd_watch_t = watch_t_r;
    cmd_watch_c = watch_c_r;
    cmd_lap_t   = lap_t_r;
    cmd_lap_c   = lap_c_r;
    view_nxt    = view_r;
    run_nxt     = run_r;
    pause_nxt   = pause_r;
    unique case (func)
      csw_pkg::FN_MODE: begin
        view_nxt = !view_r;
        if (!view_r) begin
          cmd_lap_t = watch_t_r;
          cmd_lap_c = watch_c_r;
        end
      end
      csw_pkg::FN_HOUR_UP: begin
        if (!view_r) begin
          cmd_clk_t.hours = (clk_t_r.hours == csw_pkg::HOUR_LAST) ? '0
                          : clk_t_r.hours + 5'd1;
        end
      end
      csw_pkg::FN_MIN_UP: begin
        if (!view_r) begin
          if (clk_t_r.minutes == csw_pkg::SIXTY_LAST) begin
            cmd_clk_t.minutes = '0;
            cmd_clk_t.hours   = (clk_t_r.hours == csw_pkg::HOUR_LAST) ? '0
                              : clk_t_r.hours + 5'd1;
          end else begin
            cmd_clk_t.minutes = clk_t_r.minutes + 6'd1;
          end
        end
      end
      csw_pkg::FN_ZERO_SECS: begin
        if (!view_r) begin
          cmd_clk_t.seconds = '0;
          cmd_clk_c         = '0;
        end
      end
      csw_pkg::FN_RESET: begin
        if (view_r) begin
          cmd_watch_t = '0;
          cmd_watch_c = '0;
          run_nxt     = 1'b0;
          pause_nxt   = 1'b0;
        end
      end
      csw_pkg::FN_START_STOP: begin
        if (view_r) run_nxt = !run_r;
      end
      csw_pkg::FN_PAUSE: begin
        if (view_r) pause_nxt = !pause_r;
      end
      csw_pkg::FN_LOAD: begin
        // out-of-range load values saturate
        cmd_clk_t.hours   = (in_ch.load_hours > csw_pkg::HOUR_LAST)
                          ? csw_pkg::HOUR_LAST : in_ch.load_hours;
        cmd_clk_t.minutes = (in_ch.load_minutes > csw_pkg::SIXTY_LAST)
                          ? csw_pkg::SIXTY_LAST : in_ch.load_minutes;
        cmd_clk_t.seconds = (in_ch.load_seconds > csw_pkg::SIXTY_LAST)
                          ? csw_pkg::SIXTY_LAST : in_ch.load_seconds;
        cmd_clk_c         = '0;
      end
      default: begin
      end
    endcase
  end

  csw_tick #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_watch_tick (
    .en    (run_nxt),
    .t_in  (cmd_watch_t),
    .c_in  (cmd_watch_c),
    .t_out (watch_t_nxt),
    .c_out (watch_c_nxt)
  );

  csw_tick #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_clock_tick (
    .en    (1'b1),
    .t_in  (cmd_clk_t),
    .c_in  (cmd_clk_c),
    .t_out (clk_t_nxt),
    .c_out (clk_c_nxt)
  );

  always_comb begin
    lap_t_nxt = cmd_lap_t;
    lap_c_nxt = cmd_lap_c;
    if (view_nxt && !pause_nxt) begin
      lap_t_nxt = watch_t_nxt;
      lap_c_nxt = watch_c_nxt;
    end
    res.showing_stopwatch = view_nxt;
    res.running           = run_nxt;
    res.frozen            = pause_nxt;
    if (view_nxt) begin
      res.disp_hours   = lap_t_nxt.hours;
      res.disp_minutes = lap_t_nxt.minutes;
      res.disp_seconds = lap_t_nxt.seconds;
      res.disp_centis  = 7'(lap_c_nxt);
    end else begin
      res.disp_hours   = clk_t_nxt.hours;
      res.disp_minutes = clk_t_nxt.minutes;
      res.disp_seconds = clk_t_nxt.seconds;
      res.disp_centis  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_t_r   <= '0;
      clk_c_r   <= '0;
      watch_t_r <= '0;
      watch_c_r <= '0;
      lap_t_r   <= '0;
      lap_c_r   <= '0;
      view_r    <= 1'b0;
      run_r     <= 1'b0;
      pause_r   <= 1'b0;
    end else if (accept) begin
      clk_t_r   <= clk_t_nxt;
      clk_c_r   <= clk_c_nxt;
      watch_t_r <= watch_t_nxt;
      watch_c_r <= watch_c_nxt;
      lap_t_r   <= lap_t_nxt;
      lap_c_r   <= lap_c_nxt;
      view_r    <= view_nxt;
      run_r     <= run_nxt;
      pause_r   <= pause_nxt;
    end
  end

  // output buffer: head word plus one skid word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (pop) begin
          head_vld_r <= 1'b1;
          skid_vld_r <= 1'b0;
        end
      end else if (accept) begin
        if (!head_vld_r || pop) begin
          head_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (pop) begin
        head_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) head_r <= skid_r;
    end else if (accept) begin
      if (!head_vld_r || pop) begin
        head_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign in_ch.ready              = !skid_vld_r;
  assign out_ch.valid             = head_vld_r;
  assign out_ch.showing_stopwatch = head_r.showing_stopwatch;
  assign out_ch.disp_hours        = head_r.disp_hours;
  assign out_ch.disp_minutes      = head_r.disp_minutes;
  assign out_ch.disp_seconds      = head_r.disp_seconds;
  assign out_ch.disp_centis       = head_r.disp_centis;
  assign out_ch.running           = head_r.running;
  assign out_ch.frozen            = head_r.frozen;

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> head_vld_r)
    else $error("skid word held without head word");

  a_clock_view_centis: assert property (@(posedge clk) disable iff (!rst_n)
    (head_vld_r && !head_r.showing_stopwatch) |-> (head_r.disp_centis == 7'd0))
    else $error("clock view shows non-zero hundredths");

  a_watch_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && view_r && func == csw_pkg::FN_RESET)
      |=> (!run_r && !pause_r && watch_t_r == '0))
    else $error("stopwatch reset did not clear state");

  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    (clk_t_r.hours <= csw_pkg::HOUR_LAST) && (clk_t_r.minutes <= csw_pkg::SIXTY_LAST)
      && (clk_t_r.seconds <= csw_pkg::SIXTY_LAST))
    else $error("clock time out of range");

endmodule

`default_nettype wire

[dv/csw_checker.sv]
// Scoreboard for the clock and stopwatch: predicts each display word and compares it.
module csw_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  csw_in_if           in_mon,
  csw_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  import csw_pkg::*;

  localparam logic [6:0] CENTI_LAST = 7'(TICKS_PER_SECOND_DEF - 1);

  typedef struct packed {
    hms_t       hms;
    logic [6:0] centis;
  } tally_t;

  tally_t      tod;
  tally_t      watch;
  tally_t      lap;
  logic        watch_view;
  logic        counting;
  logic        held;
  result_t     due_words[$];
  int unsigned misses = 0;
  int unsigned due_count = 0;

  assign fail_count = misses;
  assign pending    = due_count;

  function automatic hms_t bump_hours(hms_t t);
    t.hours = (t.hours >= HOUR_LAST) ? 5'd0 : t.hours + 5'd1;
    return t;
  endfunction

  // minutes carry into hours, hours wrap without carry
  function automatic hms_t bump_minutes(hms_t t);
    if (t.minutes >= SIXTY_LAST) begin
      t.minutes = '0;
      t = bump_hours(t);
    end else begin
      t.minutes = t.minutes + 6'd1;
    end
    return t;
  endfunction

  function automatic tally_t tick_on(tally_t t);
    if (t.centis >= CENTI_LAST) begin
      t.centis = '0;
      if (t.hms.seconds >= SIXTY_LAST) begin
        t.hms.seconds = '0;
        t.hms = bump_minutes(t.hms);
      end else begin
        t.hms.seconds = t.hms.seconds + 6'd1;
      end
    end else begin
      t.centis = t.centis + 7'd1;
    end
    return t;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t: MISMATCH %s", $time, msg);
    misses++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      flag_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // command, then ticks (watch if counting); in watch view lap follows unless paused
  task automatic predict_display(input logic [3:0] fn, input logic [4:0] lh,
                                 input logic [5:0] lm, input logic [5:0] ls);
    result_t r;
    case (fn)
      FN_MODE: begin
        watch_view = !watch_view;
        if (watch_view) lap = watch;
      end
      FN_HOUR_UP:    if (!watch_view) tod.hms = bump_hours(tod.hms);
      FN_MIN_UP:     if (!watch_view) tod.hms = bump_minutes(tod.hms);
      FN_ZERO_SECS: begin
        if (!watch_view) begin
          tod.hms.seconds = '0;
          tod.centis = '0;
        end
      end
      FN_RESET: begin
        if (watch_view) begin
          watch = '0;
          counting = 1'b0;
          held = 1'b0;
        end
      end
      FN_START_STOP: if (watch_view) counting = !counting;
      FN_PAUSE:      if (watch_view) held = !held;
      FN_LOAD: begin
        tod.hms.hours   = (lh > HOUR_LAST)  ? HOUR_LAST  : lh;
        tod.hms.minutes = (lm > SIXTY_LAST) ? SIXTY_LAST : lm;
        tod.hms.seconds = (ls > SIXTY_LAST) ? SIXTY_LAST : ls;
        tod.centis = '0;
      end
      default: ;
    endcase

    if (counting) watch = tick_on(watch);
    tod = tick_on(tod);
    if (watch_view && !held) lap = watch;

    r.showing_stopwatch = watch_view;
    r.disp_hours   = watch_view ? lap.hms.hours   : tod.hms.hours;
    r.disp_minutes = watch_view ? lap.hms.minutes : tod.hms.minutes;
    r.disp_seconds = watch_view ? lap.hms.seconds : tod.hms.seconds;
    r.disp_centis  = watch_view ? lap.centis      : 7'd0;
    r.running = counting;
    r.frozen  = held;
    due_words.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      tod = '0;
      watch = '0;
      lap = '0;
      watch_view = 1'b0;
      counting = 1'b0;
      held = 1'b0;
      due_words.delete();
    end else begin
      // input first, so a same-cycle result would still find its expectation
      if (in_mon.valid && in_mon.ready)
        predict_display(in_mon.func, in_mon.load_hours, in_mon.load_minutes,
                        in_mon.load_seconds);
      if (out_mon.valid && out_mon.ready) begin
        if (due_words.size() == 0) begin
          flag_mismatch("display word with none due");
        end else begin
          want = due_words.pop_front();
          check_field("showing_stopwatch", out_mon.showing_stopwatch,
                      want.showing_stopwatch);
          check_field("disp_hours", out_mon.disp_hours, want.disp_hours);
          check_field("disp_minutes", out_mon.disp_minutes, want.disp_minutes);
          check_field("disp_seconds", out_mon.disp_seconds, want.disp_seconds);
          check_field("disp_centis", out_mon.disp_centis, want.disp_centis);
          check_field("running", out_mon.running, want.running);
          check_field("frozen", out_mon.frozen, want.frozen);
        end
      end
    end
    due_count = due_words.size();
  end

endmodule

[dv/tb_top.sv]
// Testbench top: clock, reset, tick word stimulus, display backpressure and verdict.
module tb_top;
  import csw_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1700;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam logic [3:0]  FN_SPARE_LO  = 4'd9;
  localparam logic [3:0]  FN_SPARE_HI  = 4'd15;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  csw_in_if  in_ch ();
  csw_out_if out_ch ();

  clock_and_stopwatch_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int unsigned fail_count;
  int unsigned pending;

  csw_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  int unsigned snd_idle = 22;
  int unsigned rcv_idle = 58;
  bit          hold_req = 1'b0;
  bit          on_watch = 1'b0;
  int unsigned words_sent = 0;

  task automatic send_word(input logic [3:0] fn, input logic [4:0] lh,
                           input logic [5:0] lm, input logic [5:0] ls);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= fn;
    in_ch.load_hours   <= lh;
    in_ch.load_minutes <= lm;
    in_ch.load_seconds <= ls;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (fn == FN_MODE) on_watch = !on_watch;
  endtask

  // command word with junk in the load fields
  task automatic tick(input logic [3:0] fn);
    send_word(fn, 5'($urandom), 6'($urandom), 6'($urandom));
  endtask

  // receiver: random ready, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned base;
    int unsigned phase;
    bit          squeezed;
    logic [3:0]  fn;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FN_NONE;
    in_ch.load_hours   <= '0;
    in_ch.load_minutes <= '0;
    in_ch.load_seconds <= '0;
    squeezed = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset state, load extremes and saturation, wraps, wrong-view commands
    tick(FN_NONE);
    send_word(FN_LOAD, 5'd0, 6'd0, 6'd0);
    send_word(FN_LOAD, HOUR_LAST, SIXTY_LAST, SIXTY_LAST);
    tick(FN_HOUR_UP);
    send_word(FN_LOAD, 5'd12, SIXTY_LAST, 6'd30);
    tick(FN_MIN_UP);
    send_word(FN_LOAD, HOUR_LAST, SIXTY_LAST, 6'd10);
    tick(FN_MIN_UP);
    tick(FN_ZERO_SECS);
    send_word(FN_LOAD, 5'd31, 6'd63, 6'd63);
    send_word(FN_LOAD, 5'd24, 6'd60, 6'd60);
    tick(FN_RESET);
    tick(FN_START_STOP);
    tick(FN_PAUSE);
    tick(FN_SPARE_LO);
    tick(FN_SPARE_HI);
    tick(FN_MODE);
    tick(FN_HOUR_UP);
    tick(FN_MIN_UP);
    tick(FN_ZERO_SECS);
    tick(FN_START_STOP);
    tick(FN_NONE);
    tick(FN_PAUSE);
    tick(FN_NONE);
    tick(FN_PAUSE);
    send_word(FN_LOAD, 5'd7, 6'd8, 6'd9);
    tick(FN_RESET);
    tick(FN_MODE);

    base = words_sent;
    while (words_sent < base + RANDOM_WORDS) begin
      phase = (words_sent - base) * 3 / RANDOM_WORDS;
      if (phase == 1) begin
        snd_idle = 58;
        rcv_idle = 22;
      end else if (phase == 2) begin
        snd_idle = 0;
        rcv_idle = 0;
        if (!squeezed) begin
          squeezed = 1'b1;
          hold_req = 1'b1;
        end
      end

      kind = $urandom_range(99);
      if (kind < 45) begin
        // stopwatch session
        if (!on_watch) tick(FN_MODE);
        if ($urandom_range(1)) tick(FN_START_STOP);
        n = $urandom_range(40, 5);
        repeat (n) begin
          case ($urandom_range(19))
            0, 1:    fn = FN_PAUSE;
            2:       fn = FN_START_STOP;
            3:       fn = FN_RESET;
            4:       fn = 4'($urandom_range(FN_ZERO_SECS, FN_HOUR_UP));
            5:       fn = FN_LOAD;
            default: fn = FN_NONE;
          endcase
          tick(fn);
        end
        if ($urandom_range(2) == 0) tick(FN_MODE);
      end else if (kind < 65) begin
        // clock session
        if (on_watch) tick(FN_MODE);
        n = $urandom_range(30, 5);
        repeat (n) begin
          case ($urandom_range(15))
            0, 1:    fn = FN_HOUR_UP;
            2, 3:    fn = FN_MIN_UP;
            4:       fn = FN_ZERO_SECS;
            5:       fn = FN_LOAD;
            6:       fn = 4'($urandom_range(FN_PAUSE, FN_RESET));
            default: fn = FN_NONE;
          endcase
          tick(fn);
        end
      end else if (kind < 80) begin
        // run the clock from just before midnight, often across it
        if ($urandom_range(3) == 0)
          send_word(FN_LOAD, 5'd31, 6'd63, 6'd63);
        else
          send_word(FN_LOAD, HOUR_LAST, SIXTY_LAST, 6'($urandom_range(59, 57)));
        n = $urandom_range(250, 100);
        repeat (n) tick(FN_NONE);
      end else begin
        // noise over the whole command space
        n = $urandom_range(10, 1);
        repeat (n) tick(4'($urandom));
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[clock_and_stopwatch_top.f]
rtl/core/csw_pkg.sv
rtl/core/csw_if.sv
rtl/core/csw_tick.sv
rtl/core/clock_and_stopwatch_top.sv
dv/csw_checker.sv
dv/tb_top.sv
